/* hw/rtl/alcm_pkg.sv */
// Shared types, codes and constants of the alignment LCM unit.
package alcm_pkg;

  localparam int DEF_ALIGN_WIDTH = 32;
  localparam int REG_W           = 32;
  localparam int RES_W           = 64;
  localparam int ADDR_W          = 3;

  localparam logic [REG_W-1:0] UNIT_RESET = 32'd4096;

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_START  = 1'b0,
    REG_LENGTH = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    ACTION_LENGTH = 1'b0,
    ACTION_START  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } state_t;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SUB,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_STORE
  } op_t;

  typedef struct packed {
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic a_even;
    logic b_even;
    logic a_eq_b;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/alignment_lcm_unit_top.sv */
// Top level of the alignment LCM unit: configuration registers and unit wiring.
// Each item passes through load, binary GCD steps, restoring divide steps, the hand-over
// and the multiply, and waits before the multiply while an earlier result still waits at the output.
// One item at a time: the GCD and divide loops share the single subtractor, and the next item
// is taken while a result waits.
// Reset (synchronous): both units return to 4096, sequencer idle, no result held.
module alignment_lcm_unit_top #(
  parameter int ALIGN_WIDTH = alcm_pkg::DEF_ALIGN_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alcm_pkg::ADDR_W-1:0] paddr,
  input  logic [alcm_pkg::REG_W-1:0]  pwdata,
  output logic [alcm_pkg::REG_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [alcm_pkg::REG_W-1:0]  current_alignment,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [alcm_pkg::RES_W-1:0]  combined_alignment
);
  import alcm_pkg::*;

  logic [REG_W-1:0] start_align_unit;
  logic [REG_W-1:0] length_align_unit;
  logic             cfg_write;
  reg_idx_t         cfg_idx;
  ctrl_t            ctrl;
  status_t          status;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_align_unit  <= UNIT_RESET;
      length_align_unit <= UNIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_START:  start_align_unit  <= pwdata;
        REG_LENGTH: length_align_unit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START:  prdata = start_align_unit;
      REG_LENGTH: prdata = length_align_unit;
      default:    prdata = '0;
    endcase
  end

  alcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  alcm_datapath #(
    .ALIGN_WIDTH (ALIGN_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .status             (status),
    .action             (action),
    .current_alignment  (current_alignment),
    .start_unit         (start_align_unit),
    .length_unit        (length_align_unit),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .combined_alignment (combined_alignment)
  );

endmodule

/* hw/rtl/alcm_datapath.sv */
// Operand registers, shared subtract/shift unit, divider state and result register.
module alcm_datapath #(
  parameter int ALIGN_WIDTH = alcm_pkg::DEF_ALIGN_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  alcm_pkg::ctrl_t           ctrl,
  output alcm_pkg::status_t         status,
  input  logic                      action,
  input  logic [alcm_pkg::REG_W-1:0] current_alignment,
  input  logic [alcm_pkg::REG_W-1:0] start_unit,
  input  logic [alcm_pkg::REG_W-1:0] length_unit,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [alcm_pkg::RES_W-1:0] combined_alignment
);
  import alcm_pkg::*;

  localparam int W    = ALIGN_WIDTH;
  localparam int KW   = $clog2(W);
  localparam logic [KW-1:0] CNT_LAST = KW'(W - 1);

  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [W-1:0]   xs;
  logic [W-1:0]   ys;
  logic [W-1:0]   g;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [KW-1:0]  k;
  logic [KW-1:0]  cnt;
  logic           is_one;

  logic [REG_W-1:0] unit_sel;
  logic [W-1:0]     x_in;
  logic [W-1:0]     y_in;
  logic             a_ge_b;
  logic [W:0]       sub_l;
  logic [W:0]       sub_r;
  logic [W+1:0]     diff;
  logic             borrow;
  logic [2*W-1:0]   product;

  assign unit_sel = (action_t'(action) == ACTION_START) ? start_unit : length_unit;
  // A zero operand counts as one.
  assign x_in = (current_alignment[W-1:0] == '0) ? W'(1) : current_alignment[W-1:0];
  assign y_in = (unit_sel[W-1:0] == '0) ? W'(1) : unit_sel[W-1:0];

  assign a_ge_b = (a >= b);

  // The one subtractor serves both the GCD reduction and the restoring divider.
  always_comb begin
    if (ctrl.op == OP_DIV_STEP) begin
      sub_l = {rem, quo[W-1]};
      sub_r = {1'b0, g};
    end else if (a_ge_b) begin
      sub_l = {1'b0, a};
      sub_r = {1'b0, b};
    end else begin
      sub_l = {1'b0, b};
      sub_r = {1'b0, a};
    end
  end

  assign diff   = {1'b0, sub_l} - {1'b0, sub_r};
  assign borrow = diff[W+1];
  assign product = quo * ys;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        a      <= x_in;
        b      <= y_in;
        xs     <= x_in;
        ys     <= y_in;
        k      <= '0;
        is_one <= (x_in == W'(1)) && (y_in == W'(1));
      end
      OP_HALVE_BOTH: begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + KW'(1);
      end
      OP_HALVE_A: a <= a >> 1;
      OP_HALVE_B: b <= b >> 1;
      // Both odd here, so the difference is even and halves exactly.
      OP_SUB: begin
        if (a_ge_b) begin
          a <= diff[W:1];
        end else begin
          b <= diff[W:1];
        end
      end
      OP_DIV_START: begin
        g   <= a << k;
        rem <= '0;
        quo <= xs;
        cnt <= '0;
      end
      OP_DIV_STEP: begin
        if (borrow) begin
          rem <= sub_l[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        cnt <= cnt + KW'(1);
      end
      OP_STORE: begin
        combined_alignment <= is_one ? '0 : RES_W'(product);
      end
      OP_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_STORE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.a_even   = ~a[0];
  assign status.b_even   = ~b[0];
  assign status.a_eq_b   = (a == b);
  assign status.div_last = (cnt == CNT_LAST);
  assign status.out_free = ~out_valid | ~out_stall;

endmodule

/* hw/rtl/alcm_ctrl.sv */
// Sequencer that steps the shared unit through GCD, division and multiply.
module alcm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  alcm_pkg::status_t status,
  output alcm_pkg::ctrl_t   ctrl
);
  import alcm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_TWOS;
      ST_TWOS: if (!(status.a_even && status.b_even)) state_next = ST_GCD;
      ST_GCD:  if (status.a_eq_b) state_next = ST_DIV;
      ST_DIV:  if (status.div_last) state_next = ST_MUL;
      ST_MUL:  if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op  = OP_HOLD;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: if (in_valid) ctrl.op = OP_LOAD;
      // Strip common factors of two first; they are restored into the GCD later.
      ST_TWOS: if (status.a_even && status.b_even) ctrl.op = OP_HALVE_BOTH;
      ST_GCD: begin
        priority if (status.a_eq_b) begin
          ctrl.op = OP_DIV_START;
        end else if (status.a_even) begin
          ctrl.op = OP_HALVE_A;
        end else if (status.b_even) begin
          ctrl.op = OP_HALVE_B;
        end else begin
          ctrl.op = OP_SUB;
        end
      end
      ST_DIV:  ctrl.op = OP_DIV_STEP;
      ST_MUL:  if (status.out_free) ctrl.op = OP_STORE;
      default: ctrl.op = OP_HOLD;
    endcase
  end

endmodule

/* sim/tb_alignment_lcm_unit_top.sv */
// Self-checking testbench of the alignment LCM unit: directed, random and back-pressure tests.
module tb_alignment_lcm_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alcm_pkg::*;

  localparam int          ALIGN_WIDTH = DEF_ALIGN_WIDTH;
  localparam int          LATENCY     = 3 * ALIGN_WIDTH + 8;
  localparam int          CYCLE_LIMIT = 800000;
  localparam logic [63:0] OPND_MASK   = (64'd1 << ALIGN_WIDTH) - 64'd1;

  logic              clk               = 1'b0;
  logic              rst               = 1'b1;
  logic              psel              = 1'b0;
  logic              penable           = 1'b0;
  logic              pwrite            = 1'b0;
  logic [ADDR_W-1:0] paddr             = '0;
  logic [REG_W-1:0]  pwdata            = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;
  logic              in_valid          = 1'b0;
  logic              in_stall;
  logic              action            = 1'b0;
  logic [REG_W-1:0]  current_alignment = '0;
  logic              out_valid;
  logic              out_stall         = 1'b0;
  logic [RES_W-1:0]  combined_alignment;

  // Local copies of the two unit registers.
  logic [REG_W-1:0]  start_unit_cfg  = UNIT_RESET;
  logic [REG_W-1:0]  length_unit_cfg = UNIT_RESET;

  logic [RES_W-1:0]  lcm_expected[$];
  int                mismatch_count   = 0;
  int                cycle_count      = 0;
  bit                send_idle_on     = 1'b1;
  bit                recv_idle_on     = 1'b1;
  int                long_hold_cycles = 0;

  alignment_lcm_unit_top #(.ALIGN_WIDTH(ALIGN_WIDTH)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("alignment_lcm_unit_top verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic [RES_W-1:0] predict_lcm(input action_t act,
                                                   input logic [REG_W-1:0] align);
    logic [63:0] x, y, p, q, r, prod;
    x = 64'(align) & OPND_MASK;
    y = 64'((act == ACTION_START) ? start_unit_cfg : length_unit_cfg) & OPND_MASK;
    if (x == 64'd0) x = 64'd1;
    if (y == 64'd0) y = 64'd1;
    p = x;
    q = y;
    while (q != 64'd0) begin
      r = p % q;
      p = q;
      q = r;
    end
    prod = (x * y) / p;
    return (prod == 64'd1) ? 64'd0 : prod;
  endfunction

  // Register writes are only made here, with no item in flight.
  task automatic write_unit(input reg_idx_t idx, input logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_START) start_unit_cfg = value;
    else length_unit_cfg = value;
  endtask

  task automatic send_item(input action_t act, input logic [REG_W-1:0] align);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    action            <= act;
    current_alignment <= align;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lcm_expected.push_back(predict_lcm(act, align));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (lcm_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver: a random hold-off before each item, or one long one when asked.
  initial begin : stall_driver
    int hold;
    wait (!rst);
    @(posedge clk);
    forever begin
      hold = recv_idle_on ? $urandom_range(0, 12) : 0;
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [RES_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (lcm_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", combined_alignment));
      end else begin
        want = lcm_expected.pop_front();
        if (combined_alignment !== want)
          report_mismatch($sformatf("combined_alignment %h, expected %h",
                                    combined_alignment, want));
      end
    end
  end

  function automatic logic [REG_W-1:0] pick_alignment(input logic [REG_W-1:0] unit);
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(1, 64));
      4:       return 32'd1 << $urandom_range(0, 31);
      5:       return unit * 32'($urandom_range(0, 8));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_unit();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd1 << $urandom_range(0, 31);
      4:       return 32'($urandom_range(2, 1000));
      default: return $urandom();
    endcase
  endfunction

  // Reset units of 4096 against the extremes of the current alignment.
  task automatic test_reset_units;
    send_item(ACTION_START,  32'd0);
    send_item(ACTION_LENGTH, 32'd1);
    send_item(ACTION_START,  32'd4096);
    send_item(ACTION_LENGTH, 32'd8192);
    send_item(ACTION_START,  32'd3);
    send_item(ACTION_LENGTH, 32'hFFFF_FFFF);
    drain();
  endtask

  // A zero unit counts as one, and an LCM of one comes back as zero.
  task automatic test_zero_and_one_units;
    write_unit(REG_START,  32'd0);
    write_unit(REG_LENGTH, 32'd1);
    send_item(ACTION_START,  32'd0);
    send_item(ACTION_LENGTH, 32'd0);
    send_item(ACTION_START,  32'd1);
    send_item(ACTION_LENGTH, 32'd7);
    send_item(ACTION_START,  32'hFFFF_FFFF);
    send_item(ACTION_LENGTH, 32'hFFFF_FFFF);
    drain();
  endtask

  // Largest coprime operands give a product close to the full 64 bits.
  task automatic test_max_units;
    write_unit(REG_START,  32'hFFFF_FFFF);
    write_unit(REG_LENGTH, 32'hFFFF_FFFE);
    send_item(ACTION_START,  32'hFFFF_FFFE);
    send_item(ACTION_LENGTH, 32'hFFFF_FFFF);
    send_item(ACTION_START,  32'hFFFF_FFFF);
    send_item(ACTION_LENGTH, 32'd0);
    send_item(ACTION_START,  32'h8000_0000);
    send_item(ACTION_LENGTH, 32'hFFFF_FFFD);
    send_item(ACTION_START,  32'hFFFF_FFFD);
    drain();
  endtask

  task automatic test_random;
    action_t act;
    logic [REG_W-1:0] unit;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_unit(REG_START,  32'd0);
          write_unit(REG_LENGTH, 32'hFFFF_FFFF);
        end
        1: begin
          write_unit(REG_START,  32'hFFFF_FFFF);
          write_unit(REG_LENGTH, 32'd1);
        end
        default: begin
          write_unit(REG_START,  pick_unit());
          write_unit(REG_LENGTH, pick_unit());
        end
      endcase
      // Every third phase runs with neither side idling.
      send_idle_on = (phase % 3 != 2);
      recv_idle_on = (phase % 3 != 2);
      for (int n = 0; n < 130; n++) begin
        act  = action_t'($urandom_range(0, 1));
        unit = (act == ACTION_START) ? start_unit_cfg : length_unit_cfg;
        send_item(act, pick_alignment(unit));
      end
      drain();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure;
    write_unit(REG_START,  32'd4096);
    write_unit(REG_LENGTH, 32'd48);
    send_idle_on     = 1'b0;
    long_hold_cycles = 300;
    for (int n = 0; n < 24; n++)
      send_item(action_t'($urandom_range(0, 1)), $urandom());
    send_idle_on = 1'b1;
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_units();
    test_zero_and_one_units();
    test_max_units();
    test_random();
    test_backpressure();
    drain();
    repeat (LATENCY) @(posedge clk);
    if (lcm_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", lcm_expected.size()));
    if (mismatch_count == 0) begin
      $display("alignment_lcm_unit_top verification clean");
    end else begin
      $display("alignment_lcm_unit_top verification failed");
    end
    $finish;
  end

endmodule
